// ----- rtl/fpes_pkg.sv -----
package fpes_pkg;

    // Address and size widths of the flash array
    localparam int ADDR_BITS = 17;
    localparam int SIZE_W    = 18;
    localparam int CMP_W     = ((ADDR_BITS >= SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

    // Register map, index into paddr[3:2]
    localparam logic [1:0] REG_FLASH_SIZE  = 2'd0;
    localparam logic [1:0] REG_PGM_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ERASE_LIMIT = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] FLASH_SIZE_RST  = SIZE_W'(131072);
    localparam logic [7:0]        PGM_LIMIT_RST   = 8'd25;
    localparam logic [15:0]       ERASE_LIMIT_RST = 16'd1000;

    // Flash command bytes
    localparam logic [7:0] CMD_PROGRAM      = 8'h40;
    localparam logic [7:0] CMD_PGM_VERIFY   = 8'hC0;
    localparam logic [7:0] CMD_ERASE        = 8'h20;
    localparam logic [7:0] CMD_ERASE_VERIFY = 8'hA0;
    localparam logic [7:0] CMD_READ_ID      = 8'h90;
    localparam logic [7:0] CMD_READ_MODE    = 8'hFF;
    localparam logic [7:0] ERASED_BYTE      = 8'hFF;
    localparam logic [7:0] MAKER_ID         = 8'h31;
    localparam logic [7:0] DEVICE_ID        = 8'hBD;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [1:0] {
        MODE_PROGRAM  = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_IDENTIFY = 2'd2,
        MODE_READBACK = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_SEL    = 3'd0,
        OP_ADDR   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_WAIT   = 3'd4,
        OP_FINISH = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        W_10US = 2'd0,
        W_6US  = 2'd1,
        W_10MS = 2'd2
    } t_wait;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PGM_LIMIT = 2'd1,
        ST_ERA_LIMIT = 2'd2,
        ST_BAD_SIG   = 2'd3
    } t_status;

    // Bus operation sequences that one input can trigger
    typedef enum logic [3:0] {
        SC_PGM_START,
        SC_ID_START,
        SC_PGM_PULSE,
        SC_FINISH,
        SC_ERA_NEXT,
        SC_ERA_BEGIN,
        SC_ERA_VERIFY,
        SC_ERA_DONE,
        SC_ERA_PULSE,
        SC_DEV
    } t_script;

    typedef struct packed {
        t_op         op;
        logic        son;
        t_addr       addr;
        logic [7:0]  data;
        t_wait       wt;
        t_status     st;
        logic        last;
    } t_beat;

    function automatic t_beat mk(t_op op, logic son, t_addr a, logic [7:0] d,
                                 t_wait w, t_status s);
        t_beat b;
        b.op   = op;
        b.son  = son;
        b.addr = a;
        b.data = d;
        b.wt   = w;
        b.st   = s;
        b.last = 1'b0;
        return b;
    endfunction

    // One program pulse: 0x40, data, wait, 0xC0, wait, read
    function automatic t_beat pgm_op(logic [2:0] k, logic [7:0] tb);
        t_beat b;
        case (k)
            3'd0:    b = mk(OP_WRITE, 1'b0, '0, CMD_PROGRAM, W_10US, ST_OK);
            3'd1:    b = mk(OP_WRITE, 1'b0, '0, tb, W_10US, ST_OK);
            3'd2:    b = mk(OP_WAIT, 1'b0, '0, 8'h00, W_10US, ST_OK);
            3'd3:    b = mk(OP_WRITE, 1'b0, '0, CMD_PGM_VERIFY, W_10US, ST_OK);
            3'd4:    b = mk(OP_WAIT, 1'b0, '0, 8'h00, W_6US, ST_OK);
            default: b = mk(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
        endcase
        return b;
    endfunction

    // Erase pulse (steps 0-2) followed by erase verify (steps 3-6)
    function automatic t_beat era_op(logic [2:0] k, t_addr a);
        t_beat b;
        case (k)
            3'd0:    b = mk(OP_WRITE, 1'b0, '0, CMD_ERASE, W_10US, ST_OK);
            3'd1:    b = mk(OP_WRITE, 1'b0, '0, CMD_ERASE, W_10US, ST_OK);
            3'd2:    b = mk(OP_WAIT, 1'b0, '0, 8'h00, W_10MS, ST_OK);
            3'd3:    b = mk(OP_ADDR, 1'b0, a, 8'h00, W_10US, ST_OK);
            3'd4:    b = mk(OP_WRITE, 1'b0, '0, CMD_ERASE_VERIFY, W_10US, ST_OK);
            3'd5:    b = mk(OP_WAIT, 1'b0, '0, 8'h00, W_6US, ST_OK);
            default: b = mk(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
        endcase
        return b;
    endfunction

    function automatic logic [3:0] script_len(t_script sc);
        logic [3:0] n;
        unique case (sc)
            SC_PGM_START:  n = 4'd8;
            SC_ID_START:   n = 4'd4;
            SC_PGM_PULSE:  n = 4'd6;
            SC_FINISH:     n = 4'd2;
            SC_ERA_NEXT:   n = 4'd9;
            SC_ERA_BEGIN:  n = 4'd10;
            SC_ERA_VERIFY: n = 4'd4;
            SC_ERA_DONE:   n = 4'd3;
            SC_ERA_PULSE:  n = 4'd7;
            SC_DEV:        n = 4'd4;
            default:       n = 4'd1;
        endcase
        return n;
    endfunction

    // Decode one bus operation of a sequence
    function automatic t_beat script_beat(t_script sc, logic [3:0] step, t_addr a,
                                          logic [7:0] tb, t_status st);
        t_beat      b;
        logic [3:0] k2;
        logic [3:0] k3;
        logic [3:0] kv;
        k2 = step - 4'd2;
        k3 = step - 4'd3;
        kv = step + 4'd3;
        unique case (sc)
            SC_PGM_START: begin
                case (step)
                    4'd0:    b = mk(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                    4'd1:    b = mk(OP_ADDR, 1'b0, a, 8'h00, W_10US, ST_OK);
                    default: b = pgm_op(k2[2:0], tb);
                endcase
            end
            SC_ID_START: begin
                case (step)
                    4'd0:    b = mk(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                    4'd1:    b = mk(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    4'd2:    b = mk(OP_WRITE, 1'b0, '0, CMD_READ_ID, W_10US, ST_OK);
                    default: b = mk(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
                endcase
            end
            SC_PGM_PULSE: b = pgm_op(step[2:0], tb);
            SC_FINISH: begin
                case (step)
                    4'd0:    b = mk(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    default: b = mk(OP_FINISH, 1'b0, '0, 8'h00, W_10US, st);
                endcase
            end
            SC_ERA_NEXT: begin
                case (step)
                    4'd0:    b = mk(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    4'd1:    b = mk(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                    4'd2:    b = mk(OP_ADDR, 1'b0, a, 8'h00, W_10US, ST_OK);
                    default: b = pgm_op(k3[2:0], tb);
                endcase
            end
            SC_ERA_BEGIN: begin
                case (step)
                    4'd0:    b = mk(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    4'd1:    b = mk(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                    4'd2:    b = mk(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    default: b = era_op(k3[2:0], a);
                endcase
            end
            SC_ERA_VERIFY: b = era_op(kv[2:0], a);
            SC_ERA_DONE: begin
                case (step)
                    4'd0:    b = mk(OP_WRITE, 1'b0, '0, CMD_READ_MODE, W_10US, ST_OK);
                    4'd1:    b = mk(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    default: b = mk(OP_FINISH, 1'b0, '0, 8'h00, W_10US, ST_OK);
                endcase
            end
            SC_ERA_PULSE: b = era_op(step[2:0], a);
            SC_DEV: begin
                case (step)
                    4'd0:    b = mk(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    4'd1:    b = mk(OP_WRITE, 1'b0, '0, CMD_READ_ID, W_10US, ST_OK);
                    4'd2:    b = mk(OP_ADDR, 1'b0, t_addr'(1), 8'h00, W_10US, ST_OK);
                    default: b = mk(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
                endcase
            end
            default: b = mk(OP_FINISH, 1'b0, '0, 8'h00, W_10US, st);
        endcase
        b.last = (step == (script_len(sc) - 4'd1));
        return b;
    endfunction

endpackage

// ----- rtl/flash_program_erase_sequencer.sv -----
// Quick-pulse program / erase / identify sequencer for a parallel flash.
// Slave stream: tuser carries the request kind (program, erase, identify,
// or a byte read back from the flash); tdata carries chip, address, data.
// Master stream: one beat per bus operation; tuser is the operation code,
// tdata carries chip select, address, data, wait length and final status,
// tlast marks the final operation caused by one input beat.
// APB port: flash_size at 0x0, program pulse limit at 0x4, erase pulse
// limit at 0x8; writes complete in the access cycle, pready is tied high.
// Flow: an accepted beat is decoded into a sequence in a pending slot and
// moved to the emitter once the emitter is free or hands over the last
// operation of its sequence, so its first operation is offered from the
// emitter slot. The emitter issues one operation per cycle while
// m_axis_tready is high, 2 to 10 operations per input beat (none for an
// ignored beat: a start while a job runs, or a read-back while idle). The
// pending slot takes the next input beat while the emitter still drains
// the previous sequence.
// A stall on the master side holds the current operation and, once the
// pending slot is full, holds s_axis_tready low.
// Reset returns to idle, empties both slots and restores register defaults.
module flash_program_erase_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // chip[0], address[17:1], data[25:18], zero
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // chip_sel[0], select_on[1], bus_address[18:2],
                                        // bus_data[26:19], wait_kind[28:27],
                                        // status[30:29], zero[31]
    output logic [2:0]  m_axis_tuser,   // op[2:0]
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpes_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PGM,
        PH_ERA,
        PH_MFR,
        PH_DEV
    } t_phase;

    // configuration registers
    logic [SIZE_W-1:0] r_flash_size;
    logic [7:0]        r_pgm_limit;
    logic [15:0]       r_era_limit;

    // sequencer state
    t_phase      r_phase,    n_phase;
    logic        r_chip,     n_chip;
    t_addr       r_cur,      n_cur;
    logic [7:0]  r_tb,       n_tb;
    logic [15:0] r_pc,       n_pc;
    logic [1:0]  r_kind,     n_kind;
    logic [7:0]  r_maker,    n_maker;

    // pending sequence slot
    logic        r_p_valid;
    t_script     r_p_script;
    t_addr       r_p_addr;
    logic [7:0]  r_p_tb;
    t_status     r_p_st;
    logic        r_p_chip;

    // emitter slot
    logic        r_e_valid;
    t_script     r_e_script;
    t_addr       r_e_addr;
    logic [7:0]  r_e_tb;
    t_status     r_e_st;
    logic        r_e_chip;
    logic [3:0]  r_e_step;

    // decoded new sequence
    logic        c_has;
    t_script     c_script;
    t_addr       c_addr;
    logic [7:0]  c_tb;
    t_status     c_st;
    logic        c_chip;

    t_mode       in_mode;
    logic        in_chip;
    t_addr       in_addr;
    logic [7:0]  in_data;
    logic        in_fire;
    logic        cfg_wr;
    logic [CMP_W-1:0] next_addr;
    logic [CMP_W-1:0] eff_size;
    logic [CMP_W-1:0] size_ext;
    logic [15:0] pc_inc;
    logic [15:0] pgm_lim;
    logic [15:0] era_lim;
    t_beat       beat;
    logic        out_fire;
    logic        e_done;
    logic        move;

    // unpack the input beat
    assign in_mode = t_mode'(s_axis_tuser);
    assign in_chip = s_axis_tdata[0];
    assign in_addr = s_axis_tdata[ADDR_BITS:1];
    assign in_data = s_axis_tdata[ADDR_BITS+8:ADDR_BITS+1];

    assign s_axis_tready = ~r_p_valid;
    assign in_fire       = s_axis_tvalid & ~r_p_valid;

    // effective size, limits and next address
    assign size_ext  = CMP_W'(r_flash_size);
    assign next_addr = CMP_W'(r_cur) + CMP_W'(1);
    assign pc_inc    = r_pc + 16'd1;
    assign pgm_lim   = (r_pgm_limit == 8'd0) ? 16'd1 : {8'd0, r_pgm_limit};
    assign era_lim   = (r_era_limit == 16'd0) ? 16'd1 : r_era_limit;

    always_comb begin
        if (r_flash_size == '0) begin
            eff_size = CMP_W'(1);
        end else if (size_ext > (CMP_W'(1) << ADDR_BITS)) begin
            eff_size = CMP_W'(1) << ADDR_BITS;
        end else begin
            eff_size = size_ext;
        end
    end

    // decide the next state and the sequence for an accepted beat
    always_comb begin
        n_phase  = r_phase;
        n_chip   = r_chip;
        n_cur    = r_cur;
        n_tb     = r_tb;
        n_pc     = r_pc;
        n_kind   = r_kind;
        n_maker  = r_maker;
        c_has    = 1'b0;
        c_script = SC_FINISH;
        c_addr   = r_cur;
        c_tb     = r_tb;
        c_st     = ST_OK;
        c_chip   = r_chip;
        if (in_fire) begin
            if (r_phase == PH_IDLE) begin
                if (in_mode != MODE_READBACK) begin
                    n_chip = in_chip;
                    c_chip = in_chip;
                    n_pc   = '0;
                    n_kind = in_mode;
                    c_has  = 1'b1;
                    case (in_mode)
                        MODE_PROGRAM: begin
                            n_cur    = in_addr;
                            n_tb     = in_data;
                            c_script = SC_PGM_START;
                            c_addr   = in_addr;
                            c_tb     = in_data;
                            n_phase  = PH_PGM;
                        end
                        MODE_ERASE: begin
                            n_cur    = '0;
                            n_tb     = 8'h00;
                            c_script = SC_PGM_START;
                            c_addr   = '0;
                            c_tb     = 8'h00;
                            n_phase  = PH_PGM;
                        end
                        default: begin
                            n_cur    = '0;
                            c_script = SC_ID_START;
                            c_addr   = '0;
                            n_phase  = PH_MFR;
                        end
                    endcase
                end
            end else if (in_mode == MODE_READBACK) begin
                c_has = 1'b1;
                unique case (r_phase)
                    PH_PGM: begin
                        if (in_data == r_tb) begin
                            if (r_kind != MODE_ERASE) begin
                                c_script = SC_FINISH;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_pc = '0;
                                if (next_addr < eff_size) begin
                                    n_cur    = next_addr[ADDR_BITS-1:0];
                                    c_addr   = next_addr[ADDR_BITS-1:0];
                                    c_script = SC_ERA_NEXT;
                                end else begin
                                    n_cur    = '0;
                                    c_addr   = '0;
                                    c_script = SC_ERA_BEGIN;
                                    n_phase  = PH_ERA;
                                end
                            end
                        end else begin
                            n_pc = pc_inc;
                            if (pc_inc >= pgm_lim) begin
                                c_script = SC_FINISH;
                                c_st     = ST_PGM_LIMIT;
                                n_phase  = PH_IDLE;
                            end else begin
                                c_script = SC_PGM_PULSE;
                            end
                        end
                    end
                    PH_ERA: begin
                        if (in_data == ERASED_BYTE) begin
                            if (next_addr < eff_size) begin
                                n_cur    = next_addr[ADDR_BITS-1:0];
                                c_addr   = next_addr[ADDR_BITS-1:0];
                                c_script = SC_ERA_VERIFY;
                            end else begin
                                c_script = SC_ERA_DONE;
                                n_phase  = PH_IDLE;
                            end
                        end else begin
                            n_pc = pc_inc;
                            if (pc_inc >= era_lim) begin
                                c_script = SC_FINISH;
                                c_st     = ST_ERA_LIMIT;
                                n_phase  = PH_IDLE;
                            end else begin
                                c_script = SC_ERA_PULSE;
                            end
                        end
                    end
                    PH_MFR: begin
                        n_maker  = in_data;
                        c_script = SC_DEV;
                        n_phase  = PH_DEV;
                    end
                    PH_DEV: begin
                        c_script = SC_FINISH;
                        c_st     = (r_maker == MAKER_ID && in_data == DEVICE_ID) ?
                                   ST_OK : ST_BAD_SIG;
                        n_phase  = PH_IDLE;
                    end
                    default: begin
                        c_has   = 1'b0;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // emitter decode
    assign beat     = script_beat(r_e_script, r_e_step, r_e_addr, r_e_tb, r_e_st);
    assign out_fire = r_e_valid & m_axis_tready;
    assign e_done   = out_fire & beat.last;
    assign move     = r_p_valid & (~r_e_valid | e_done);

    assign m_axis_tvalid = r_e_valid;
    assign m_axis_tuser  = beat.op;
    assign m_axis_tlast  = beat.last;
    assign m_axis_tdata  = {1'b0, beat.st, beat.wt, beat.data, beat.addr, beat.son, r_e_chip};

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_FLASH_SIZE:  prdata = 32'(r_flash_size);
            REG_PGM_LIMIT:   prdata = 32'(r_pgm_limit);
            REG_ERASE_LIMIT: prdata = 32'(r_era_limit);
            default:         prdata = '0;
        endcase
    end

    // hold state, pending slot and emitter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_size <= FLASH_SIZE_RST;
            r_pgm_limit  <= PGM_LIMIT_RST;
            r_era_limit  <= ERASE_LIMIT_RST;
            r_phase      <= PH_IDLE;
            r_chip       <= 1'b0;
            r_cur        <= '0;
            r_tb         <= 8'h00;
            r_pc         <= '0;
            r_kind       <= 2'd0;
            r_maker      <= 8'h00;
            r_p_valid    <= 1'b0;
            r_e_valid    <= 1'b0;
            r_e_step     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_FLASH_SIZE:  r_flash_size <= pwdata[SIZE_W-1:0];
                    REG_PGM_LIMIT:   r_pgm_limit  <= pwdata[7:0];
                    REG_ERASE_LIMIT: r_era_limit  <= pwdata[15:0];
                    default:         ;
                endcase
            end

            r_phase <= n_phase;
            r_chip  <= n_chip;
            r_cur   <= n_cur;
            r_tb    <= n_tb;
            r_pc    <= n_pc;
            r_kind  <= n_kind;
            r_maker <= n_maker;

            // fill the pending slot
            if (in_fire && c_has) begin
                r_p_valid  <= 1'b1;
                r_p_script <= c_script;
                r_p_addr   <= c_addr;
                r_p_tb     <= c_tb;
                r_p_st     <= c_st;
                r_p_chip   <= c_chip;
            end else if (move) begin
                r_p_valid <= 1'b0;
            end

            // advance or reload the emitter
            if (move) begin
                r_e_valid  <= 1'b1;
                r_e_script <= r_p_script;
                r_e_addr   <= r_p_addr;
                r_e_tb     <= r_p_tb;
                r_e_st     <= r_p_st;
                r_e_chip   <= r_p_chip;
                r_e_step   <= '0;
            end else if (e_done) begin
                r_e_valid <= 1'b0;
            end else if (out_fire) begin
                r_e_step <= r_e_step + 4'd1;
            end
        end
    end

endmodule

// ----- tb/tb_flash_program_erase_sequencer.sv -----
module tb_flash_program_erase_sequencer;

    import fpes_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 120;

    // One request or read-back byte sent to the sequencer
    typedef struct {
        t_mode      mode;
        logic       chip;
        t_addr      addr;
        logic [7:0] data;
    } t_request;

    // One bus operation as the sequencer should emit it
    typedef struct {
        t_op        op;
        logic       chip_sel;
        logic       select_on;
        t_addr      bus_address;
        logic [7:0] bus_data;
        t_wait      wait_kind;
        t_status    status;
        logic       last;
    } t_bus_op;

    typedef enum logic [2:0] {
        JP_IDLE,
        JP_PROGRAM,
        JP_ERASE,
        JP_MAKER,
        JP_DEVICE
    } t_job_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and job state of the predictor
    logic [SIZE_W-1:0] cfg_size = FLASH_SIZE_RST;
    logic [7:0]        cfg_pgm_limit = PGM_LIMIT_RST;
    logic [15:0]       cfg_erase_limit = ERASE_LIMIT_RST;
    t_job_phase        job_phase = JP_IDLE;
    logic              job_chip = 1'b0;
    t_addr             job_addr = '0;
    logic [7:0]        job_byte = '0;
    int                job_pulses = 0;
    t_mode             job_mode = MODE_PROGRAM;
    logic [7:0]        maker_byte = '0;

    t_request requests_pending[$];
    t_bus_op  bus_ops_due[$];
    t_request req_on_bus;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    bit beat_held = 1'b0;
    bit in_taken = 1'b0;
    bit hold_req = 1'b0;
    int tx_gap = 0;
    int rx_stall = 0;
    int long_hold = 0;
    int cycle_count = 0;
    int error_count = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int finish_count[4] = '{0, 0, 0, 0};

    flash_program_erase_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int limit_of(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // Bytes covered by an erase: zero acts as one, clamp to the address space
    function automatic int erase_span();
        int sz;
        sz = int'(cfg_size);
        if (sz == 0) sz = 1;
        if (sz > (1 << ADDR_BITS)) sz = 1 << ADDR_BITS;
        return sz;
    endfunction

    task automatic emit_op(input t_op op, input logic son, input t_addr a,
                           input logic [7:0] d, input t_wait w, input t_status st);
        t_bus_op b;
        b.op          = op;
        b.chip_sel    = job_chip;
        b.select_on   = son;
        b.bus_address = a;
        b.bus_data    = d;
        b.wait_kind   = w;
        b.status      = st;
        b.last        = 1'b0;
        bus_ops_due.push_back(b);
    endtask

    task automatic emit_program_pulse();
        emit_op(OP_WRITE, 1'b0, '0, CMD_PROGRAM, W_10US, ST_OK);
        emit_op(OP_WRITE, 1'b0, '0, job_byte, W_10US, ST_OK);
        emit_op(OP_WAIT, 1'b0, '0, 8'h00, W_10US, ST_OK);
        emit_op(OP_WRITE, 1'b0, '0, CMD_PGM_VERIFY, W_10US, ST_OK);
        emit_op(OP_WAIT, 1'b0, '0, 8'h00, W_6US, ST_OK);
        emit_op(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
    endtask

    task automatic emit_erase_verify();
        emit_op(OP_ADDR, 1'b0, job_addr, 8'h00, W_10US, ST_OK);
        emit_op(OP_WRITE, 1'b0, '0, CMD_ERASE_VERIFY, W_10US, ST_OK);
        emit_op(OP_WAIT, 1'b0, '0, 8'h00, W_6US, ST_OK);
        emit_op(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
    endtask

    task automatic emit_erase_pulse();
        emit_op(OP_WRITE, 1'b0, '0, CMD_ERASE, W_10US, ST_OK);
        emit_op(OP_WRITE, 1'b0, '0, CMD_ERASE, W_10US, ST_OK);
        emit_op(OP_WAIT, 1'b0, '0, 8'h00, W_10MS, ST_OK);
        emit_erase_verify();
    endtask

    task automatic emit_finish(input t_status st);
        emit_op(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
        emit_op(OP_FINISH, 1'b0, '0, 8'h00, W_10US, st);
        job_phase = JP_IDLE;
    endtask

    // Work out the bus operations that one accepted beat causes
    task automatic predict_bus_ops(input t_request rq);
        int      n_before;
        int      next_addr;
        t_bus_op tail;
        n_before = bus_ops_due.size();
        if (job_phase == JP_IDLE) begin
            if (rq.mode != MODE_READBACK) begin
                job_chip   = rq.chip;
                job_pulses = 0;
                job_mode   = rq.mode;
                emit_op(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                case (rq.mode)
                    MODE_PROGRAM: begin
                        job_addr = rq.addr;
                        job_byte = rq.data;
                        emit_op(OP_ADDR, 1'b0, job_addr, 8'h00, W_10US, ST_OK);
                        emit_program_pulse();
                        job_phase = JP_PROGRAM;
                    end
                    MODE_ERASE: begin
                        job_addr = '0;
                        job_byte = 8'h00;
                        emit_op(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                        emit_program_pulse();
                        job_phase = JP_PROGRAM;
                    end
                    default: begin
                        job_addr = '0;
                        emit_op(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                        emit_op(OP_WRITE, 1'b0, '0, CMD_READ_ID, W_10US, ST_OK);
                        emit_op(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
                        job_phase = JP_MAKER;
                    end
                endcase
            end
        end else if (rq.mode == MODE_READBACK) begin
            case (job_phase)
                JP_PROGRAM: begin
                    if (rq.data == job_byte) begin
                        if (job_mode != MODE_ERASE) begin
                            emit_finish(ST_OK);
                        end else begin
                            // byte zeroed: move on, or start erasing after the last one
                            emit_op(OP_SEL, 1'b0, '0, 8'h00, W_10US, ST_OK);
                            next_addr  = int'(job_addr) + 1;
                            job_pulses = 0;
                            emit_op(OP_SEL, 1'b1, '0, 8'h00, W_10US, ST_OK);
                            if (next_addr < erase_span()) begin
                                job_addr = t_addr'(next_addr);
                                emit_op(OP_ADDR, 1'b0, job_addr, 8'h00, W_10US, ST_OK);
                                emit_program_pulse();
                            end else begin
                                job_addr = '0;
                                emit_op(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                                emit_erase_pulse();
                                job_phase = JP_ERASE;
                            end
                        end
                    end else begin
                        job_pulses++;
                        if (job_pulses >= limit_of(int'(cfg_pgm_limit)))
                            emit_finish(ST_PGM_LIMIT);
                        else
                            emit_program_pulse();
                    end
                end
                JP_ERASE: begin
                    if (rq.data == ERASED_BYTE) begin
                        next_addr = int'(job_addr) + 1;
                        if (next_addr < erase_span()) begin
                            job_addr = t_addr'(next_addr);
                            emit_erase_verify();
                        end else begin
                            emit_op(OP_WRITE, 1'b0, '0, CMD_READ_MODE, W_10US, ST_OK);
                            emit_finish(ST_OK);
                        end
                    end else begin
                        job_pulses++;
                        if (job_pulses >= limit_of(int'(cfg_erase_limit)))
                            emit_finish(ST_ERA_LIMIT);
                        else
                            emit_erase_pulse();
                    end
                end
                JP_MAKER: begin
                    maker_byte = rq.data;
                    emit_op(OP_ADDR, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    emit_op(OP_WRITE, 1'b0, '0, CMD_READ_ID, W_10US, ST_OK);
                    emit_op(OP_ADDR, 1'b0, t_addr'(1), 8'h00, W_10US, ST_OK);
                    emit_op(OP_READ, 1'b0, '0, 8'h00, W_10US, ST_OK);
                    job_phase = JP_DEVICE;
                end
                JP_DEVICE: begin
                    if (maker_byte == MAKER_ID && rq.data == DEVICE_ID)
                        emit_finish(ST_OK);
                    else
                        emit_finish(ST_BAD_SIG);
                end
                default: job_phase = JP_IDLE;
            endcase
        end
        // mark the final operation of this beat
        if (bus_ops_due.size() > n_before) begin
            tail = bus_ops_due.pop_back();
            tail.last = 1'b1;
            bus_ops_due.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("bus op %0d %s: got 0x%0h, want 0x%0h",
                                   beats_checked, name, got, want));
    endtask

    // Sample both streams: predict on accepted requests, compare emitted operations
    always @(posedge i_clk) begin
        t_bus_op want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_bus_ops(req_on_bus);
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                rx_stall = rx_idle ? $urandom_range(0, 7) : 0;
                if (bus_ops_due.size() == 0) begin
                    report_error($sformatf("bus op %0d: op %0d with nothing expected",
                                           beats_checked, m_axis_tuser));
                end else begin
                    want = bus_ops_due.pop_front();
                    check_field("op", 32'(m_axis_tuser), 32'(want.op));
                    check_field("chip_sel", 32'(m_axis_tdata[0]), 32'(want.chip_sel));
                    check_field("select_on", 32'(m_axis_tdata[1]), 32'(want.select_on));
                    check_field("bus_address", 32'(m_axis_tdata[18:2]),
                                32'(want.bus_address));
                    check_field("bus_data", 32'(m_axis_tdata[26:19]), 32'(want.bus_data));
                    check_field("wait_kind", 32'(m_axis_tdata[28:27]), 32'(want.wait_kind));
                    check_field("status", 32'(m_axis_tdata[30:29]), 32'(want.status));
                    check_field("pad", 32'(m_axis_tdata[31]), 32'd0);
                    check_field("last", 32'(m_axis_tlast), 32'(want.last));
                    if (want.op == OP_FINISH) finish_count[want.status]++;
                end
                beats_checked++;
            end
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("ERROR: timeout, %0d operations still expected", bus_ops_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driver: offer queued beats with random gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!beat_held || in_taken) begin
            in_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                beat_held = 1'b0;
                s_axis_tvalid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
                req_on_bus = requests_pending.pop_front();
                beat_held = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, req_on_bus.data, req_on_bus.addr, req_on_bus.chip};
                s_axis_tuser <= req_on_bus.mode;
                tx_gap = tx_idle ? $urandom_range(0, 7) : 0;
            end else begin
                beat_held = 1'b0;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Operation receiver: random stalls plus an occasional long hold
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            long_hold = LONG_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [7:0] other_byte(input logic [7:0] good);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == good) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic t_addr any_addr();
        return t_addr'($urandom());
    endfunction

    task automatic send(input t_mode m, input logic c, input t_addr a,
                        input logic [7:0] d, input bit counted);
        t_request rq;
        rq.mode = m;
        rq.chip = c;
        rq.addr = a;
        rq.data = d;
        requests_pending.push_back(rq);
        if (counted) items_sent++;
    endtask

    // Byte read back from the flash; a job is running, so a stray start may precede it
    task automatic readback(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            send(t_mode'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), any_addr(),
                 8'($urandom_range(0, 255)), 1'b0);
        send(MODE_READBACK, 1'($urandom_range(0, 1)), any_addr(),
             8'($urandom_range(0, 255)) & 8'h00 | b, 1'b1);
    endtask

    task automatic job_program(input logic c, input t_addr a, input logic [7:0] d,
                               input int fails);
        int pl;
        pl = limit_of(int'(cfg_pgm_limit));
        send(MODE_PROGRAM, c, a, d, 1'b1);
        for (int k = 0; k < fails && k < pl; k++) readback(other_byte(d));
        if (fails < pl) readback(d);
    endtask

    task automatic job_identify(input logic c, input bit good_maker, input bit good_device);
        send(MODE_IDENTIFY, c, any_addr(), 8'($urandom_range(0, 255)), 1'b1);
        readback(good_maker ? MAKER_ID : other_byte(MAKER_ID));
        readback(good_device ? DEVICE_ID : other_byte(DEVICE_ID));
    endtask

    // Zero every byte, then erase and verify; fail_at < 0 means no program failure
    task automatic job_erase(input logic c, input int fail_at, input int verify_fail_pct);
        int sz;
        int pl;
        int el;
        int a;
        int k;
        int pulses;
        sz = erase_span();
        pl = limit_of(int'(cfg_pgm_limit));
        el = limit_of(int'(cfg_erase_limit));
        send(MODE_ERASE, c, any_addr(), 8'($urandom_range(0, 255)), 1'b1);
        for (a = 0; a < sz; a++) begin
            if (a == fail_at) begin
                repeat (pl) readback(other_byte(8'h00));
                return;
            end
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, (pl - 1 < 2) ? pl - 1 : 2) : 0;
            repeat (k) readback(other_byte(8'h00));
            readback(8'h00);
        end
        pulses = 0;
        a = 0;
        while (a < sz) begin
            if ($urandom_range(0, 99) < verify_fail_pct) begin
                readback(other_byte(ERASED_BYTE));
                pulses++;
                if (pulses >= el) return;
            end else begin
                readback(ERASED_BYTE);
                a++;
            end
        end
    endtask

    // Mix of jobs; full_erase allows erases that run to the end
    task automatic random_jobs(input int budget, input bit full_erase);
        int stop_at;
        int pl;
        int fails;
        int fail_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pl = limit_of(int'(cfg_pgm_limit));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if (pl <= 8 && $urandom_range(0, 3) == 0)
                        fails = pl;
                    else
                        fails = $urandom_range(0, (pl - 1 < 3) ? pl - 1 : 3);
                    job_program(1'($urandom_range(0, 1)), any_addr(),
                                8'($urandom_range(0, 255)), fails);
                end
                4, 5: job_identify(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                                   $urandom_range(0, 3) != 0);
                6, 7, 8: begin
                    if (!full_erase)
                        fail_at = $urandom_range(0, 3);
                    else if (pl <= 8 && $urandom_range(0, 4) == 0)
                        fail_at = $urandom_range(0, erase_span() - 1);
                    else
                        fail_at = -1;
                    job_erase(1'($urandom_range(0, 1)), fail_at, 20);
                end
                default: send(MODE_READBACK, 1'($urandom_range(0, 1)), any_addr(),
                              8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FLASH_SIZE:  cfg_size = value[SIZE_W-1:0];
            REG_PGM_LIMIT:   cfg_pgm_limit = value[7:0];
            REG_ERASE_LIMIT: cfg_erase_limit = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int size, input int pgm_limit, input int erase_limit);
        write_reg(REG_FLASH_SIZE, 32'(size));
        write_reg(REG_PGM_LIMIT, 32'(pgm_limit));
        write_reg(REG_ERASE_LIMIT, 32'(erase_limit));
    endtask

    // Hold off new requests until every queued beat is sent and answered
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (requests_pending.size() != 0 || beat_held || bus_ops_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed at reset values: corner addresses and data, identify pass and fail
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send(MODE_READBACK, 1'b1, any_addr(), 8'hFF, 1'b0);
        job_program(1'b0, '0, 8'h00, 0);
        job_program(1'b1, t_addr'(17'h1FFFF), 8'hFF, 1);
        job_identify(1'b0, 1'b1, 1'b1);
        job_identify(1'b1, 1'b1, 1'b0);
        wait_until_idle();

        // Directed with a two-byte chip: pulse limits and retries
        set_config(2, 2, 2);
        job_program(1'b1, any_addr(), 8'hA5, 2);
        send(MODE_ERASE, 1'b0, any_addr(), 8'h5A, 1'b1);
        readback(8'h00);
        readback(8'h00);
        readback(ERASED_BYTE);
        readback(8'h7F);
        readback(ERASED_BYTE);
        send(MODE_ERASE, 1'b1, any_addr(), 8'h00, 1'b1);
        readback(8'h00);
        readback(8'h00);
        readback(8'h00);
        readback(8'hFE);
        send(MODE_ERASE, 1'b0, '0, 8'hFF, 1'b1);
        readback(8'h00);
        readback(8'h11);
        readback(8'h22);
        wait_until_idle();

        // Back-to-back requests with a long receiver hold so the input backs up
        set_config(3, 4, 3);
        tx_idle = 1'b0;
        random_jobs(30, 1'b1);
        hold_req = 1'b1;
        wait_until_idle();
        tx_idle = 1'b1;
        random_jobs(20, 1'b1);
        wait_until_idle();

        // Lowest settings, no idling on either side
        set_config(0, 0, 0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_jobs(35, 1'b1);
        wait_until_idle();

        // Oversized chip: erases end on a program failure near the start
        set_config(32'h3FFFF, 2, 1000);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_jobs(25, 1'b0);
        wait_until_idle();

        // Largest pulse limits on a small chip
        set_config(4, 255, 65535);
        random_jobs(35, 1'b1);
        wait_until_idle();

        // Full-size chip value, programs and identifies mostly
        set_config(131072, 1, 1);
        random_jobs(10, 1'b0);
        wait_until_idle();

        $display("summary: %0d requests and read-back bytes sent, %0d bus operations checked",
                 items_sent, beats_checked);
        $display("summary: jobs ended ok %0d, program limit %0d, erase limit %0d, bad id %0d",
                 finish_count[0], finish_count[1], finish_count[2], finish_count[3]);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fpes_pkg.sv
rtl/flash_program_erase_sequencer.sv
tb/tb_flash_program_erase_sequencer.sv
